// ===== rtl/uartx_pkg.sv =====
// Shared types and constants for the 8N1 UART transceiver.
package uartx_pkg;

    localparam logic [15:0] BIT_PERIOD_RST  = 16'd109;
    localparam logic [15:0] HALF_PERIOD_RST = 16'd55;
    localparam logic [7:0]  RX_DROP_BYTE    = 8'hFF;
    localparam logic [3:0]  TX_FRAME_BITS   = 4'd9;
    localparam logic [3:0]  RX_DATA_BITS    = 4'd8;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd1;

    typedef enum logic [1:0] {
        RX_IDLE   = 2'd0,
        RX_CENTER = 2'd1,
        RX_SAMPLE = 2'd2
    } t_rx_mode;

    typedef struct packed {
        logic       rx_line;
        logic       tx_start;
        logic [7:0] tx_byte;
    } t_in;

    typedef struct packed {
        logic       tx_line;
        logic       tx_busy;
        logic       rx_valid;
        logic [7:0] rx_byte;
    } t_out;

    typedef struct packed {
        logic [15:0] bit_period;
        logic [15:0] half_period;
    } t_cfg;

endpackage

// ===== rtl/uartx_tx.sv =====
// Transmit side: bit timer and frame shifter, advanced one tick per item.
module uartx_tx (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_start,
    input  logic [7:0]          i_byte,
    input  uartx_pkg::t_cfg     i_cfg,
    output logic                o_line,
    output logic                o_busy
);

    logic [15:0] r_ticks, n_ticks;
    logic [3:0]  r_bits_left, n_bits_left;
    logic [7:0]  r_shift, n_shift;
    logic        r_level, n_level;

    always_comb begin
        n_ticks     = r_ticks;
        n_bits_left = r_bits_left;
        n_shift     = r_shift;
        n_level     = r_level;
        if (r_bits_left == 4'd0) begin
            if (i_start) begin
                n_level     = 1'b0;
                n_shift     = i_byte;
                n_ticks     = 16'd0;
                n_bits_left = uartx_pkg::TX_FRAME_BITS;
            end
        end else if (r_ticks >= i_cfg.bit_period) begin
            n_ticks = 16'd0;
            if (r_bits_left > 4'd1) begin
                n_level = r_shift[0];
                n_shift = {1'b0, r_shift[7:1]};
            end else begin
                n_level = 1'b1;
            end
            n_bits_left = r_bits_left - 4'd1;
        end else begin
            n_ticks = r_ticks + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks     <= 16'd0;
            r_bits_left <= 4'd0;
            r_shift     <= 8'd0;
            r_level     <= 1'b1;
        end else if (i_step) begin
            r_ticks     <= n_ticks;
            r_bits_left <= n_bits_left;
            r_shift     <= n_shift;
            r_level     <= n_level;
        end
    end

    // Result shows the state after this tick.
    assign o_line = n_level;
    assign o_busy = (n_bits_left != 4'd0);

endmodule

// ===== rtl/uartx_rx.sv =====
// Receive side: edge detect, centering wait and bit sampler.
module uartx_rx (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_line,
    input  uartx_pkg::t_cfg     i_cfg,
    output logic                o_got,
    output logic [7:0]          o_hold
);

    logic [15:0]         r_ticks, n_ticks;
    logic [3:0]          r_bits_left, n_bits_left;
    logic [7:0]          r_shift, n_shift;
    logic                r_prev, n_prev;
    uartx_pkg::t_rx_mode r_mode, n_mode;
    logic [7:0]          r_hold, n_hold;
    logic                n_got;

    always_comb begin
        n_ticks     = r_ticks;
        n_bits_left = r_bits_left;
        n_shift     = r_shift;
        n_mode      = r_mode;
        n_hold      = r_hold;
        n_got       = 1'b0;
        n_prev      = i_line;
        case (r_mode)
            uartx_pkg::RX_CENTER: begin
                if (r_ticks >= i_cfg.half_period) begin
                    n_ticks     = 16'd0;
                    n_mode      = uartx_pkg::RX_SAMPLE;
                    n_bits_left = uartx_pkg::RX_DATA_BITS;
                    n_shift     = 8'd0;
                end else begin
                    n_ticks = r_ticks + 16'd1;
                end
            end
            uartx_pkg::RX_SAMPLE: begin
                if (r_ticks >= i_cfg.bit_period) begin
                    n_ticks     = 16'd0;
                    n_shift     = {i_line, r_shift[7:1]};
                    n_bits_left = r_bits_left - 4'd1;
                    if (n_bits_left == 4'd0) begin
                        n_mode = uartx_pkg::RX_IDLE;
                        if (n_shift != uartx_pkg::RX_DROP_BYTE) begin
                            n_hold = n_shift;
                            n_got  = 1'b1;
                        end
                    end
                end else begin
                    n_ticks = r_ticks + 16'd1;
                end
            end
            default: begin
                // idle, and the unused code behaves as idle
                n_mode = uartx_pkg::RX_IDLE;
                if (r_prev && !i_line) begin
                    n_mode  = uartx_pkg::RX_CENTER;
                    n_ticks = 16'd0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks     <= 16'd0;
            r_bits_left <= 4'd0;
            r_shift     <= 8'd0;
            r_prev      <= 1'b1;
            r_mode      <= uartx_pkg::RX_IDLE;
            r_hold      <= 8'd0;
        end else if (i_step) begin
            r_ticks     <= n_ticks;
            r_bits_left <= n_bits_left;
            r_shift     <= n_shift;
            r_prev      <= n_prev;
            r_mode      <= n_mode;
            r_hold      <= n_hold;
        end
    end

    assign o_got  = n_got;
    assign o_hold = n_hold;

endmodule

// ===== rtl/uart_transceiver_8n1_top.sv =====
// Top level of the timer-paced 8N1 UART transceiver with output skid buffer.
//
// Usage:
//   Each input item is one tick of the bit timer: the receive line level, a
//   transmit request and the byte to send. Every accepted item yields exactly
//   one result item: transmit line level, busy flag, a one-tick receive
//   strobe and the last received byte, all showing the state after that tick.
//   Results go to the result register, or to the skid entry while that is held.
//   Throughput: one item per cycle while the skid entry is empty; the transmit
//   and receive timers each update in a single pass of compare-and-increment
//   logic on 16-bit counts. Output side: result register plus one skid entry.
//   When the receiver stalls, the item in flight parks in the skid entry and
//   the input stall rises the next cycle; it drops once the skid entry drains.
//   Configuration: index 0 = bit period, 1 = half period (ticks minus one).
//   Writes are always ready and are registered; other indexes are ignored.
//   Reset (synchronous, active low): line idle high, receiver idle, periods
//   back to 109 and 55, no result pending.
module uart_transceiver_8n1_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input item channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  uartx_pkg::t_in                      i_in,
    // result item channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output uartx_pkg::t_out                     o_out,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [uartx_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [15:0]                         i_cfg_data
);

    uartx_pkg::t_cfg r_cfg;
    uartx_pkg::t_out r_out, r_skid, w_new;
    logic            r_out_vld, r_skid_vld;
    logic            w_accept, w_out_take, w_out_free;
    logic            w_tx_line, w_tx_busy, w_rx_got;
    logic [7:0]      w_rx_hold;

    // ---------------- configuration registers ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_period  <= uartx_pkg::BIT_PERIOD_RST;
            r_cfg.half_period <= uartx_pkg::HALF_PERIOD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                uartx_pkg::CFG_BIT_PERIOD:  r_cfg.bit_period  <= i_cfg_data;
                uartx_pkg::CFG_HALF_PERIOD: r_cfg.half_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- tick datapath ----------------
    // Input is stalled only while the skid entry is occupied.
    assign w_accept = i_in_valid && !r_skid_vld;

    uartx_tx u_tx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_accept),
        .i_start (i_in.tx_start),
        .i_byte  (i_in.tx_byte),
        .i_cfg   (r_cfg),
        .o_line  (w_tx_line),
        .o_busy  (w_tx_busy)
    );

    uartx_rx u_rx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_accept),
        .i_line  (i_in.rx_line),
        .i_cfg   (r_cfg),
        .o_got   (w_rx_got),
        .o_hold  (w_rx_hold)
    );

    always_comb begin
        w_new.tx_line  = w_tx_line;
        w_new.tx_busy  = w_tx_busy;
        w_new.rx_valid = w_rx_got;
        w_new.rx_byte  = w_rx_hold;
    end

    // ---------------- result register + skid ----------------
    assign w_out_take = r_out_vld && !i_out_stall;
    assign w_out_free = !r_out_vld || w_out_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else if (w_accept) begin
                r_out <= w_new;
            end
        end else if (w_accept) begin
            r_skid <= w_new;
        end
    end

    assign o_in_stall  = r_skid_vld;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // ---------------- assertions ----------------
    // Skid entry is only ever filled behind a held result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry valid with empty result register");

    // A dropped byte value never shows with the receive strobe.
    a_no_ff_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.rx_valid) |-> (r_out.rx_byte != uartx_pkg::RX_DROP_BYTE))
        else $error("received 0xFF delivered");

    // Line is idle high whenever the transmitter is not busy.
    a_idle_line_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.tx_busy) |-> r_out.tx_line)
        else $error("tx line low while not busy");

    // A stalled result with a full skid must not let a new item in.
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && i_out_stall) |=> r_skid_vld)
        else $error("skid entry lost under stall");

endmodule
